@@ hdl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

	localparam logic [20:0] ReplCp    = 21'h00FFFD;
	localparam logic [7:0]  LeadMin   = 8'hC2;
	localparam logic [7:0]  LeadMax   = 8'hF4;
	localparam logic [7:0]  Lead3Min  = 8'hE0;
	localparam logic [7:0]  Lead4Min  = 8'hF0;
	localparam logic [7:0]  LeadE0    = 8'hE0;
	localparam logic [7:0]  LeadED    = 8'hED;
	localparam logic [7:0]  LeadF0    = 8'hF0;
	localparam logic [7:0]  LeadF4    = 8'hF4;
	localparam logic [7:0]  ContMin   = 8'h80;
	localparam logic [7:0]  ContMax   = 8'hBF;
	localparam logic [7:0]  ContE0Min = 8'hA0;
	localparam logic [7:0]  ContEDMax = 8'h9F;
	localparam logic [7:0]  ContF0Min = 8'h90;
	localparam logic [7:0]  ContF4Max = 8'h8F;
	localparam logic [5:0]  ContMask  = 6'h3F;

	// Open sequence; a lead of zero means none is open.
	typedef struct packed {
		logic [7:0]  lead;
		logic [1:0]  taken;
		logic [1:0]  needed;
		logic [20:0] partial;
	} seq_t;

	// Results of one input byte: cnt items, all U+FFFD replacements except the
	// last, which carries last_cp and last_repl.
	typedef struct packed {
		logic [2:0]  cnt;
		logic [20:0] last_cp;
		logic        last_repl;
		logic        fin;
	} desc_t;

endpackage

@@ hdl/u8d_dec.sv @@
// Per-byte decode step: next sequence state and the result descriptor.
module u8d_dec (
	input  u8d_pkg::seq_t  seq,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	output u8d_pkg::seq_t  seq_next,
	output u8d_pkg::desc_t desc
);

	logic        pending;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        in_range;
	logic [1:0]  taken_inc;
	logic [20:0] partial_inc;
	logic [2:0]  fail_cnt;

	always_comb begin
		pending = (seq.lead != 8'h00);
		lo = u8d_pkg::ContMin;
		hi = u8d_pkg::ContMax;
		if (seq.taken == 2'd0) begin
			if (seq.lead == u8d_pkg::LeadE0) begin
				lo = u8d_pkg::ContE0Min;
			end else if (seq.lead == u8d_pkg::LeadED) begin
				hi = u8d_pkg::ContEDMax;
			end else if (seq.lead == u8d_pkg::LeadF0) begin
				lo = u8d_pkg::ContF0Min;
			end else if (seq.lead == u8d_pkg::LeadF4) begin
				hi = u8d_pkg::ContF4Max;
			end
		end
		in_range    = (data_byte >= lo) && (data_byte <= hi);
		taken_inc   = seq.taken + 2'd1;
		partial_inc = {seq.partial[14:0], data_byte[5:0] & u8d_pkg::ContMask};
		fail_cnt    = {1'b0, seq.taken} + 3'd1;

		seq_next       = seq;
		desc.cnt       = 3'd0;
		desc.last_cp   = u8d_pkg::ReplCp;
		desc.last_repl = 1'b1;
		desc.fin       = final_byte;

		if (pending && in_range) begin
			if (taken_inc >= seq.needed) begin
				desc.cnt       = 3'd1;
				desc.last_cp   = partial_inc;
				desc.last_repl = 1'b0;
				seq_next       = '0;
			end else if (final_byte) begin
				desc.cnt = {1'b0, taken_inc} + 3'd1;
				seq_next = '0;
			end else begin
				seq_next.taken   = taken_inc;
				seq_next.partial = partial_inc;
			end
		end else begin
			// A broken sequence first yields its replacements, then the byte
			// starts over.
			desc.cnt = pending ? fail_cnt : 3'd0;
			seq_next = '0;
			if (data_byte[7] == 1'b0) begin
				desc.cnt       = desc.cnt + 3'd1;
				desc.last_cp   = {13'd0, data_byte};
				desc.last_repl = 1'b0;
			end else if (data_byte < u8d_pkg::LeadMin || data_byte > u8d_pkg::LeadMax) begin
				desc.cnt = desc.cnt + 3'd1;
			end else if (final_byte) begin
				desc.cnt = desc.cnt + 3'd1;
			end else begin
				seq_next.lead = data_byte;
				if (data_byte < u8d_pkg::Lead3Min) begin
					seq_next.needed  = 2'd1;
					seq_next.partial = {16'd0, data_byte[4:0]};
				end else if (data_byte < u8d_pkg::Lead4Min) begin
					seq_next.needed  = 2'd2;
					seq_next.partial = {17'd0, data_byte[3:0]};
				end else begin
					seq_next.needed  = 2'd3;
					seq_next.partial = {18'd0, data_byte[2:0]};
				end
			end
		end
	end

endmodule

@@ hdl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder with U+FFFD replacement.
//
//   channel | direction | tdata                 | tuser                 | tlast
//   s_*     | in        | [7:0] data_byte       | -                     | final_byte
//   m_*     | out       | [20:0] code_point     | [0] replaced,         | run_end
//           |           |                       | [1] string_end        |
//
// A byte is decoded in the cycle it is accepted; its results go to the output
// register, or to the skid slot while that is busy. One byte per cycle is taken
// while m_tready is high and each byte yields at most one result; a byte with
// more holds the output until all are taken, and a skid slot lets one more in.
// Reset clears the open sequence and empties both result slots.
// Back-pressure on m_tready fills the skid slot, which then drops s_tready.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_tuser,  // [0] replaced, [1] string_end
	output logic        m_tlast   // run_end
);

	u8d_pkg::seq_t  seq_q;
	u8d_pkg::seq_t  seq_next;
	u8d_pkg::desc_t desc;
	u8d_pkg::desc_t out_q;
	u8d_pkg::desc_t skid_q;
	logic [2:0]     out_rem_q;
	logic           skid_vld_q;
	logic           s_fire;
	logic           new_desc;
	logic           out_last;
	logic           out_free;

	u8d_dec u_dec (
		.seq        (seq_q),
		.data_byte  (s_tdata),
		.final_byte (s_tlast),
		.seq_next   (seq_next),
		.desc       (desc)
	);

	assign s_tready = !skid_vld_q;
	assign s_fire   = s_tvalid && s_tready;
	assign new_desc = s_fire && (desc.cnt != 3'd0);
	assign out_last = (out_rem_q == 3'd1);
	assign out_free = (out_rem_q == 3'd0) || (out_last && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			out_rem_q  <= 3'd0;
			skid_vld_q <= 1'b0;
		end else begin
			if (s_fire) begin
				seq_q <= seq_next;
			end
			if (out_free) begin
				if (skid_vld_q) begin
					out_rem_q  <= skid_q.cnt;
					skid_vld_q <= 1'b0;
				end else if (new_desc) begin
					out_rem_q <= desc.cnt;
				end else begin
					out_rem_q <= 3'd0;
				end
			end else begin
				if (m_tready) begin
					out_rem_q <= out_rem_q - 3'd1;
				end
				if (new_desc) begin
					skid_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (new_desc) begin
				out_q <= desc;
			end
		end else if (new_desc) begin
			skid_q <= desc;
		end
	end

	assign m_tvalid = (out_rem_q != 3'd0);
	assign m_tdata  = {3'd0, out_last ? out_q.last_cp : u8d_pkg::ReplCp};
	assign m_tuser  = {out_last && out_q.fin, out_last ? out_q.last_repl : 1'b1};
	assign m_tlast  = out_last;

endmodule
